/* hdl/dstq_pkg.sv */
// Shared types and constants for the deadline-sorted timer queue.
package dstq_pkg;

    localparam int unsigned KIND_W      = 2;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned THR_W       = 16;
    localparam int unsigned ELAPSED_W   = 16;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned NFIRE_W     = $clog2(MAX_RESULTS + 1);
    localparam logic [THR_W-1:0] THR_RESET = 16'd7500;

    localparam logic [KIND_W-1:0] KIND_SET    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    localparam logic ACT_WAKEUP  = 1'b0;
    localparam logic ACT_MESSAGE = 1'b1;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    typedef struct packed {
        logic [31:0] deadline;
        logic        action;
        logic [7:0]  target;
        logic [31:0] payload;
    } t_entry;

    typedef struct packed {
        logic              fired;
        logic [SLOT_W-1:0] slot;
        logic              action;
        logic [7:0]        target;
        logic [31:0]       payload;
        logic              status;
        logic              last;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UL0,
        S_UL1,
        S_UL2,
        S_ULDONE,
        S_SETW,
        S_IN0,
        S_IN1,
        S_IN3,
        S_TK0,
        S_TK1,
        S_TK2,
        S_OUT
    } t_state;

endpackage

/* hdl/deadline_sorted_timer_queue_top.sv */
// Deadline-sorted timer queue: linked list of timer slots held in on-chip memory.
//
// Timers live in two memories with registered reads (entry data and next link) walked by a
// sequencer; one transaction is taken at a time. A set walks the list once to unlink the slot
// if it is queued and, unless its interval is at most the threshold and it fires at once, once
// to insert it; a remove of a queued slot walks it once to unlink, at one entry a cycle. A tick
// fires due timers from the list head. The next input transaction is taken while a result
// still waits on the output register. s_tdata packs, from bit 0: slot[3:0], interval[35:4],
// action[36], target[44:37], payload[76:45], elapsed[92:77]; s_tuser is kind. m_tdata
// packs: slot[3:0], action[4], target[12:5], payload[44:13]; m_tuser is fired[0], status[1];
// m_tlast ends the results of one input transaction. No clearing pass is needed after reset.
module deadline_sorted_timer_queue_top
    import dstq_pkg::*;
#(
    parameter int unsigned MAX_TIMERS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,  // slot, interval, action, target, payload, elapsed
    input  logic [1:0]   i_s_tuser,  // kind
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [47:0]  o_m_tdata,  // slot, action, target, payload
    output logic [1:0]   o_m_tuser,  // fired, status
    output logic         o_m_tlast
);

    localparam int unsigned IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int unsigned LW = $clog2(MAX_TIMERS + 1);

    t_entry          mem_data [MAX_TIMERS];
    logic [IW-1:0]   mem_link [MAX_TIMERS];
    t_entry          r_rd_data;
    logic [IW-1:0]   r_rd_link;

    t_state          r_state, n_state;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [IW-1:0]   r_slot, n_slot;
    logic [31:0]     r_interval, n_interval;
    logic            r_action, n_action;
    logic [7:0]      r_target, n_target;
    logic [31:0]     r_payload, n_payload;
    logic [31:0]     r_dl, n_dl;
    logic [31:0]     r_now, n_now;
    logic [IW-1:0]   r_head, n_head;
    logic [LW-1:0]   r_len, n_len;
    logic [IW-1:0]   r_cur, n_cur;
    logic [IW-1:0]   r_prev, n_prev;
    logic            r_have_prev, n_have_prev;
    logic [LW-1:0]   r_cnt, n_cnt;
    logic [IW-1:0]   r_slink, n_slink;
    logic [NFIRE_W-1:0] r_nfire, n_nfire;
    logic [MAX_TIMERS-1:0] r_valid, n_valid;
    logic [THR_W-1:0] r_thr;
    t_res            r_pend, n_pend;
    logic            r_more, n_more;
    t_res            r_out, n_out;
    logic            r_ovalid, n_ovalid;

    logic [IW-1:0]   raddr;
    logic            w_data_en;
    t_entry          w_data;
    logic            w_link_en;
    logic [IW-1:0]   w_link_addr;
    logic [IW-1:0]   w_link_data;
    logic            out_free;
    logic [SLOT_W-1:0] in_slot;
    t_res            res_empty;

    assign in_slot   = i_s_tdata[3:0];
    assign out_free  = !r_ovalid || i_m_tready;
    assign res_empty = '{fired: 1'b0, slot: '0, action: 1'b0, target: '0, payload: '0,
                         status: ST_OK, last: 1'b1};

    always_ff @(posedge i_clk) begin
        if (w_data_en) begin
            mem_data[r_slot] <= w_data;
        end
        if (w_link_en) begin
            mem_link[w_link_addr] <= w_link_data;
        end
        r_rd_data <= mem_data[raddr];
        r_rd_link <= mem_link[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_now    <= '0;
            r_head   <= '0;
            r_len    <= '0;
            r_valid  <= '0;
            r_thr    <= THR_RESET;
            r_ovalid <= 1'b0;
            r_nfire  <= '0;
            r_more   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_now    <= n_now;
            r_head   <= n_head;
            r_len    <= n_len;
            r_valid  <= n_valid;
            r_ovalid <= n_ovalid;
            r_nfire  <= n_nfire;
            r_more   <= n_more;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_slot      <= n_slot;
        r_interval  <= n_interval;
        r_action    <= n_action;
        r_target    <= n_target;
        r_payload   <= n_payload;
        r_dl        <= n_dl;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_cnt       <= n_cnt;
        r_slink     <= n_slink;
        r_pend      <= n_pend;
        r_out       <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_interval  = r_interval;
        n_action    = r_action;
        n_target    = r_target;
        n_payload   = r_payload;
        n_dl        = r_dl;
        n_now       = r_now;
        n_head      = r_head;
        n_len       = r_len;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_cnt       = r_cnt;
        n_slink     = r_slink;
        n_nfire     = r_nfire;
        n_valid     = r_valid;
        n_pend      = r_pend;
        n_more      = r_more;
        n_out       = r_out;
        n_ovalid    = r_ovalid && !i_m_tready;
        raddr       = r_head;
        w_data_en   = 1'b0;
        w_data      = '{deadline: r_now + r_interval, action: r_action, target: r_target,
                        payload: r_payload};
        w_link_en   = 1'b0;
        w_link_addr = r_slot;
        w_link_data = '0;
        o_s_tready  = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_kind     = i_s_tuser;
                    n_slot     = IW'(in_slot);
                    n_interval = i_s_tdata[35:4];
                    n_action   = i_s_tdata[36];
                    n_target   = i_s_tdata[44:37];
                    n_payload  = i_s_tdata[76:45];
                    n_pend     = res_empty;
                    n_more     = 1'b0;
                    n_nfire    = '0;
                    n_state    = S_OUT;
                    case (i_s_tuser)
                        KIND_SET: begin
                            if (32'(in_slot) < MAX_TIMERS) begin
                                if (r_valid[IW'(in_slot)] && (r_len != '0)) begin
                                    n_state = S_UL0;
                                end else begin
                                    n_state = S_SETW;
                                end
                            end
                        end
                        KIND_REMOVE: begin
                            if (r_len == '0) begin
                                n_pend.status = ST_EMPTY;
                            end else if ((32'(in_slot) < MAX_TIMERS) &&
                                         r_valid[IW'(in_slot)]) begin
                                n_state = S_UL0;
                            end
                        end
                        KIND_TICK: begin
                            n_now   = r_now + 32'(i_s_tdata[92:77]);
                            n_state = S_TK0;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_UL0: begin
                raddr   = r_slot;
                n_state = S_UL1;
            end
            S_UL1: begin
                n_slink        = r_rd_link;
                n_valid[r_slot] = 1'b0;
                if (r_head == r_slot) begin
                    n_head  = r_rd_link;
                    n_len   = r_len - 1'b1;
                    n_state = S_ULDONE;
                end else begin
                    n_prev  = r_head;
                    n_cnt   = LW'(1);
                    raddr   = r_head;
                    n_state = S_UL2;
                end
            end
            S_UL2: begin
                if (r_cnt < r_len) begin
                    if (r_rd_link == r_slot) begin
                        w_link_en   = 1'b1;
                        w_link_addr = r_prev;
                        w_link_data = r_slink;
                        n_len       = r_len - 1'b1;
                        n_state     = S_ULDONE;
                    end else begin
                        n_prev = r_rd_link;
                        n_cnt  = r_cnt + 1'b1;
                        raddr  = r_rd_link;
                    end
                end else begin
                    n_state = S_ULDONE;
                end
            end
            S_ULDONE: begin
                n_state = (r_kind == KIND_SET) ? S_SETW : S_OUT;
            end
            S_SETW: begin
                w_data_en = 1'b1;
                n_dl      = r_now + r_interval;
                if (r_interval <= 32'(r_thr)) begin
                    n_pend.fired   = 1'b1;
                    n_pend.slot    = SLOT_W'(r_slot);
                    n_pend.action  = r_action;
                    n_pend.target  = r_target;
                    n_pend.payload = (r_action == ACT_MESSAGE) ? r_payload : '0;
                    n_state        = S_OUT;
                end else begin
                    n_state = S_IN0;
                end
            end
            S_IN0: begin
                n_valid[r_slot] = 1'b1;
                if (r_len == '0) begin
                    n_head      = r_slot;
                    w_link_en   = 1'b1;
                    w_link_addr = r_slot;
                    w_link_data = '0;
                    n_len       = r_len + 1'b1;
                    n_state     = S_OUT;
                end else begin
                    raddr       = r_head;
                    n_cur       = r_head;
                    n_cnt       = '0;
                    n_have_prev = 1'b0;
                    n_state     = S_IN1;
                end
            end
            S_IN1: begin
                w_link_en   = 1'b1;
                w_link_addr = r_slot;
                if (r_dl < r_rd_data.deadline) begin
                    w_link_data = r_cur;
                    if (r_have_prev) begin
                        n_state = S_IN3;
                    end else begin
                        n_head  = r_slot;
                        n_len   = r_len + 1'b1;
                        n_state = S_OUT;
                    end
                end else if (LW'(r_cnt + 1'b1) < r_len) begin
                    w_link_en   = 1'b0;
                    n_prev      = r_cur;
                    n_have_prev = 1'b1;
                    n_cnt       = r_cnt + 1'b1;
                    n_cur       = r_rd_link;
                    raddr       = r_rd_link;
                end else begin
                    w_link_data = '0;
                    n_prev      = r_cur;
                    n_state     = S_IN3;
                end
            end
            S_IN3: begin
                w_link_en   = 1'b1;
                w_link_addr = r_prev;
                w_link_data = r_slot;
                n_len       = r_len + 1'b1;
                n_state     = S_OUT;
            end
            S_TK0: begin
                if ((r_len != '0) && (r_nfire < NFIRE_W'(MAX_RESULTS))) begin
                    n_state = S_TK1;
                end else begin
                    n_pend  = res_empty;
                    n_more  = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_TK1: begin
                if (r_rd_data.deadline <= r_now) begin
                    n_pend.fired   = 1'b1;
                    n_pend.slot    = SLOT_W'(r_head);
                    n_pend.action  = r_rd_data.action;
                    n_pend.target  = r_rd_data.target;
                    n_pend.payload = (r_rd_data.action == ACT_MESSAGE) ?
                                     r_rd_data.payload : '0;
                    n_pend.status  = ST_OK;
                    n_pend.last    = 1'b1;
                    n_valid[r_head] = 1'b0;
                    n_head         = r_rd_link;
                    n_len          = r_len - 1'b1;
                    n_nfire        = r_nfire + 1'b1;
                    n_more         = 1'b0;
                    if ((r_len == LW'(1)) ||
                        (r_nfire == NFIRE_W'(MAX_RESULTS - 1))) begin
                        n_state = S_OUT;
                    end else begin
                        raddr   = r_rd_link;
                        n_state = S_TK2;
                    end
                end else begin
                    n_pend  = res_empty;
                    n_more  = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_TK2: begin
                n_more      = (r_rd_data.deadline <= r_now);
                n_pend.last = !(r_rd_data.deadline <= r_now);
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out    = r_pend;
                    n_ovalid = 1'b1;
                    n_state  = r_more ? S_TK0 : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {3'b000, r_out.payload, r_out.target, r_out.action, r_out.slot};
    assign o_m_tuser  = {r_out.status, r_out.fired};
    assign o_m_tlast  = r_out.last;

endmodule

/* hdl/dstq_checker.sv */
// Port-level checks for the deadline-sorted timer queue, bound to the top level.
module dstq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) &&
                                         $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled output transaction changed");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tlast && (o_m_tdata == 48'd0)))
        else $error("result without a fired timer is not last or not clear");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (!o_m_tuser[0] && o_m_tlast))
        else $error("empty-queue status on a fired result");

    a_wakeup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0] && !o_m_tdata[4]) |-> (o_m_tdata[44:13] == 32'd0))
        else $error("wakeup result carries a payload");

endmodule

bind deadline_sorted_timer_queue_top dstq_checker u_dstq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
